[design/handheld_memory_map_with_oam_dma_assert.svh]
// Assertion macros used by the memory map design file.
`ifndef HANDHELD_MEMORY_MAP_WITH_OAM_DMA_ASSERT_SVH
`define HANDHELD_MEMORY_MAP_WITH_OAM_DMA_ASSERT_SVH
`ifndef SYNTH
// Check a property on clk_i, skipped while rst_ni is low.
`define HMM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hmm assertion failed");
// Check a property on clk_i, also during reset.
`define HMM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("hmm assertion failed");
`else
`define HMM_ASSERT(lbl, prop)
`define HMM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/hmm_pkg.sv]
package hmm_pkg;

  localparam int DmaLengthDef = 160;
  localparam int ClocksPerDmaByteDef = 4;
  localparam int DmaCntW = 8;
  localparam int VramDepth = 8192;
  localparam int WramDepth = 8192;
  localparam int OamDepth = 160;
  localparam int IoDepth = 128;
  localparam int HramDepth = 128;
  // VRAM and work RAM share one RAM; OAM, I/O and high RAM share another.
  localparam int BigDepth = VramDepth + WramDepth;
  localparam int SmallDepth = 512;
  localparam int ClrW = 14;

  localparam logic [1:0] FuncRead = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncTick = 2'd2;

  localparam logic [2:0] SelLocal = 3'd0;
  localparam logic [2:0] SelTimer = 3'd1;
  localparam logic [2:0] SelJoypad = 3'd2;
  localparam logic [2:0] SelPpu = 3'd3;
  localparam logic [2:0] SelCartRom = 3'd4;
  localparam logic [2:0] SelCartRam = 3'd5;
  localparam logic [2:0] SelNone = 3'd6;

  localparam logic [1:0] CfgTimer = 2'd0;
  localparam logic [1:0] CfgPpu = 2'd1;
  localparam logic [1:0] CfgJoypad = 2'd2;
  localparam logic [1:0] CfgCart = 2'd3;

  localparam logic [15:0] AddrJoyp = 16'hFF00;
  localparam logic [15:0] AddrIf = 16'hFF0F;
  localparam logic [15:0] AddrDma = 16'hFF46;
  localparam logic [15:0] AddrIe = 16'hFFFF;

  typedef struct packed {
    logic timer;
    logic ppu;
    logic joypad;
    logic cart;
  } cfg_t;

  typedef enum logic [2:0] {
    RegJoy, RegVram, RegWram, RegOam, RegIf, RegIo, RegHram, RegOther
  } region_e;

  // Device that serves an address under the current attach settings.
  function automatic logic [2:0] classify(logic [15:0] a, cfg_t c);
    logic [2:0] s;
    if (c.timer && a >= 16'hFF04 && a <= 16'hFF07) s = SelTimer;
    else if (a == AddrJoyp) s = c.joypad ? SelJoypad : SelLocal;
    else if (a == AddrIe) s = SelLocal;
    else if (c.ppu && a >= 16'hFF40 && a <= 16'hFF4B && a != AddrDma) s = SelPpu;
    else if (a < 16'h8000) s = c.cart ? SelCartRom : SelNone;
    else if (a < 16'hA000) s = SelLocal;
    else if (a < 16'hC000) s = c.cart ? SelCartRam : SelNone;
    else if (a >= 16'hFEA0 && a < 16'hFF00) s = SelNone;
    else s = SelLocal;
    return s;
  endfunction

  function automatic logic forwarded(logic [2:0] s);
    return (s != SelLocal) && (s != SelNone);
  endfunction

  // Local store that holds an address.
  function automatic region_e region(logic [15:0] a);
    region_e r;
    if (a == AddrJoyp) r = RegJoy;
    else if (a == AddrIf) r = RegIf;
    else if (a >= 16'h8000 && a < 16'hA000) r = RegVram;
    else if (a >= 16'hC000 && a < 16'hFE00) r = RegWram;
    else if (a >= 16'hFE00 && a < 16'hFEA0) r = RegOam;
    else if (a >= 16'hFF00 && a < 16'hFF80) r = RegIo;
    else if (a >= 16'hFF80) r = RegHram;
    else r = RegOther;
    return r;
  endfunction

endpackage

[design/hmm_ram.sv]
module hmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 128,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one port, read the other through a registered output.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/handheld_memory_map_with_oam_dma.sv]
// Byte bus decoder for a handheld memory map with local VRAM, work RAM, OAM,
// I/O and high RAM, plus a 160-byte OAM DMA. VRAM and work RAM live in one
// RAM, OAM, I/O and high RAM in a second. Each command goes from acceptance
// through the read and done states to the done strobe (address, memory read,
// update), as the RAMs have a registered read port; busy falls in the done
// cycle, so the next command may be accepted there. After reset the block
// zeroes its memories in one sweep, with busy high. Results appear with the
// one-cycle done_o strobe, stay registered, and cannot be stalled; dma_*
// outputs are valid with done_o.
module handheld_memory_map_with_oam_dma import hmm_pkg::*; #(
  parameter int DMA_LENGTH = DmaLengthDef,
  parameter int CLOCKS_PER_DMA_BYTE = ClocksPerDmaByteDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic        cfg_data_i,
  input  logic [1:0]  func_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  wdata_i,
  input  logic [2:0]  cycles_i,
  input  logic        timer_irq_i,
  input  logic        joypad_irq_i,
  input  logic [7:0]  dma_byte_i,
  output logic [7:0]  rdata_o,
  output logic [2:0]  dev_sel_o,
  output logic        dev_write_o,
  output logic [15:0] dev_addr_o,
  output logic [7:0]  dev_wdata_o,
  output logic        dma_active_o,
  output logic [15:0] dma_src_addr_o,
  output logic        dma_src_external_o
);

`include "handheld_memory_map_with_oam_dma_assert.svh"

  localparam logic [DmaCntW-1:0] DmaLen = DmaCntW'(DMA_LENGTH);
  localparam logic [3:0] Cpb = 4'(CLOCKS_PER_DMA_BYTE);

  typedef enum logic [1:0] {StClear, StIdle, StRead, StDone} state_e;

  state_e state_q, state_d;
  cfg_t cfg_q;
  logic [ClrW-1:0] clr_q;
  logic [1:0] func_q;
  logic [15:0] addr_q;
  logic [7:0] wdata_q, dbyte_q;
  logic [2:0] cycles_q;
  logic tirq_q, jirq_q;
  logic [7:0] if_q, if_d;
  logic [7:0] page_q, page_d;
  logic [DmaCntW-1:0] cnt_q, cnt_d;
  logic [2:0] acc_q, acc_d;
  logic done_q;
  logic [7:0] rdata_q, rdata_d, dwdata_q, dwdata_d;
  logic [2:0] sel_q, sel_d;
  logic dwrite_q, dwrite_d;
  logic [15:0] daddr_q, daddr_d;

  logic dma_run;
  logic [15:0] dma_addr;
  logic [15:0] raddr;
  logic [7:0] big_rd, small_rd, local_rd;
  logic big_we, small_we;
  logic [13:0] big_ra, big_wa;
  logic [8:0] small_ra, small_wa;
  logic [7:0] big_wd, small_wd;
  logic [2:0] src_sel, cpu_sel;
  logic [3:0] acc_sum;
  logic [7:0] dma_b;
  region_e cpu_reg, rd_reg;

  // Slot in the small RAM: OAM low, I/O next, high RAM on top.
  function automatic logic [8:0] small_addr(region_e r, logic [15:0] a);
    logic [8:0] s;
    case (r)
      RegOam:  s = {1'b0, a[7:0]};
      RegHram: s = {2'b11, a[6:0]};
      default: s = {2'b10, a[6:0]};
    endcase
    return s;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != StIdle);
  assign done_o = done_q;
  assign rdata_o = rdata_q;
  assign dev_sel_o = sel_q;
  assign dev_write_o = dwrite_q;
  assign dev_addr_o = daddr_q;
  assign dev_wdata_o = dwdata_q;

  // DMA status as it stands after the last command.
  assign dma_run = cnt_q < DmaLen;
  assign dma_addr = {page_q, 8'h00} + {8'h00, cnt_q};
  assign src_sel = classify(dma_addr, cfg_q);
  assign dma_active_o = dma_run;
  assign dma_src_addr_o = dma_run ? dma_addr : 16'h0000;
  assign dma_src_external_o = dma_run && forwarded(src_sel);

  // Read the DMA source on ticks, the CPU address otherwise.
  assign raddr = (func_q == FuncTick) ? dma_addr : addr_q;
  assign rd_reg = region(raddr);
  assign big_ra = {rd_reg == RegWram, raddr[12:0]};
  assign small_ra = small_addr(rd_reg, raddr);

  hmm_ram #(.Width(8), .Depth(BigDepth)) u_big (
    .clk_i, .we_i(big_we), .waddr_i(big_wa), .wdata_i(big_wd),
    .raddr_i(big_ra), .rdata_o(big_rd));
  hmm_ram #(.Width(8), .Depth(SmallDepth)) u_small (
    .clk_i, .we_i(small_we), .waddr_i(small_wa), .wdata_i(small_wd),
    .raddr_i(small_ra), .rdata_o(small_rd));

  // Merge tick interrupt flags ahead of any read of IF.
  always_comb begin
    if_d = if_q;
    if (func_q == FuncTick) begin
      if (tirq_q && cfg_q.timer) if_d = if_d | 8'h04;
      if (jirq_q && cfg_q.joypad) if_d = if_d | 8'h10;
    end
  end

  // Select the local byte at the read address.
  always_comb begin
    case (rd_reg)
      RegJoy:                   local_rd = (small_rd & 8'h30) | 8'hCF;
      RegVram, RegWram:         local_rd = big_rd;
      RegOam, RegIo, RegHram:   local_rd = small_rd;
      RegIf:                    local_rd = if_d;
      default:                  local_rd = 8'hFF;
    endcase
  end

  assign cpu_sel = classify(addr_q, cfg_q);
  assign cpu_reg = region(addr_q);
  assign acc_sum = ({1'b0, acc_q} + {1'b0, cycles_q} > 4'd7) ? 4'd7
                 : {1'b0, acc_q} + {1'b0, cycles_q};

  always_comb begin
    if (forwarded(src_sel)) dma_b = dbyte_q;
    else if (src_sel == SelNone) dma_b = 8'hFF;
    else dma_b = local_rd;
  end

  // Next state, memory clear, and command finish: results, local writes and DMA progress.
  always_comb begin
    state_d = state_q;
    page_d = page_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    rdata_d = 8'h00;
    sel_d = SelNone;
    dwrite_d = 1'b0;
    daddr_d = 16'h0000;
    dwdata_d = 8'h00;
    big_we = 1'b0;
    small_we = 1'b0;
    big_wa = {cpu_reg == RegWram, addr_q[12:0]};
    small_wa = small_addr(cpu_reg, addr_q);
    big_wd = wdata_q;
    small_wd = wdata_q;
    case (state_q)
      StClear: begin
        big_we = 1'b1;
        small_we = clr_q < ClrW'(SmallDepth);
        big_wa = clr_q;
        small_wa = clr_q[8:0];
        big_wd = 8'h00;
        small_wd = 8'h00;
        if (clr_q == {ClrW{1'b1}}) state_d = StIdle;
      end
      StIdle: if (start) state_d = StRead;
      StRead: state_d = StDone;
      StDone: begin
        state_d = StIdle;
        if (func_q == FuncRead || func_q == FuncWrite) begin
          sel_d = cpu_sel;
          if (forwarded(cpu_sel)) begin
            daddr_d = addr_q;
            if (func_q == FuncWrite) begin
              dwrite_d = 1'b1;
              dwdata_d = wdata_q;
            end
          end else if (cpu_sel == SelNone) begin
            rdata_d = (func_q == FuncRead) ? 8'hFF : 8'h00;
          end else if (func_q == FuncRead) begin
            rdata_d = local_rd;
          end else begin
            case (cpu_reg)
              RegVram, RegWram:               big_we = 1'b1;
              RegOam, RegJoy, RegIo, RegHram: small_we = 1'b1;
              default: ;
            endcase
            if (addr_q == AddrDma) begin
              page_d = wdata_q;
              cnt_d = '0;
              acc_d = 3'd0;
            end
          end
        end else if (func_q == FuncTick && dma_run) begin
          if (acc_sum >= Cpb) begin
            acc_d = 3'(acc_sum - Cpb);
            small_we = 1'b1;
            small_wa = {1'b0, cnt_q};
            small_wd = dma_b;
            cnt_d = cnt_q + 1'b1;
          end else begin
            acc_d = acc_sum[2:0];
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state, clear counter, configuration, the command word, IF, DMA progress and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      cfg_q <= '1;
      if_q <= 8'h00;
      page_q <= 8'h00;
      cnt_q <= DmaLen;
      acc_q <= 3'd0;
      done_q <= 1'b0;
      func_q <= FuncRead;
      addr_q <= 16'h0000;
      wdata_q <= 8'h00;
      cycles_q <= 3'd0;
      tirq_q <= 1'b0;
      jirq_q <= 1'b0;
      dbyte_q <= 8'h00;
      rdata_q <= 8'h00;
      sel_q <= SelNone;
      dwrite_q <= 1'b0;
      daddr_q <= 16'h0000;
      dwdata_q <= 8'h00;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == StDone);
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgTimer:  cfg_q.timer <= cfg_data_i;
          CfgPpu:    cfg_q.ppu <= cfg_data_i;
          CfgJoypad: cfg_q.joypad <= cfg_data_i;
          CfgCart:   cfg_q.cart <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StIdle && start) begin
        func_q <= func_i;
        addr_q <= address_i;
        wdata_q <= wdata_i;
        cycles_q <= cycles_i;
        tirq_q <= timer_irq_i;
        jirq_q <= joypad_irq_i;
        dbyte_q <= dma_byte_i;
      end
      if (state_q == StDone) begin
        page_q <= page_d;
        cnt_q <= cnt_d;
        acc_q <= acc_d;
        rdata_q <= rdata_d;
        sel_q <= sel_d;
        dwrite_q <= dwrite_d;
        daddr_q <= daddr_d;
        dwdata_q <= dwdata_d;
        if (func_q == FuncWrite && cpu_sel == SelLocal && cpu_reg == RegIf) begin
          if_q <= wdata_q;
        end else begin
          if_q <= if_d;
        end
      end
    end
  end

  `HMM_ASSERT(a_done_not_busy, done_o |-> !busy)
  `HMM_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `HMM_ASSERT(a_cnt_bound, cnt_q <= DmaLen)
  `HMM_ASSERT_ALWAYS(a_reset_idle_dma, !rst_ni |-> !done_o)

endmodule
